>>> rtl/core/ksr_pkg.sv
package ksr_pkg;

	localparam int KEY_W    = 8;
	localparam int SLOT_W   = 14;
	localparam int NODE_W   = 4;
	localparam int STATUS_W = 2;
	localparam int CRC_W    = 16;
	localparam int COUNT_W  = 5;

	// slot map entry: assigned flag on top of the node index
	localparam int ENTRY_W = NODE_W + 1;

	localparam logic MODE_KEY    = 1'b0;
	localparam logic MODE_ASSIGN = 1'b1;

	localparam logic [STATUS_W-1:0] ROUTE_MAPPED  = 2'd0;
	localparam logic [STATUS_W-1:0] ROUTE_DEFAULT = 2'd1;
	localparam logic [STATUS_W-1:0] ROUTE_NONE    = 2'd2;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	typedef logic [ENTRY_W-1:0] entry_t;

endpackage

>>> rtl/core/ksr_in_if.sv
interface ksr_in_if;
	import ksr_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [KEY_W-1:0]  key_byte;
	logic              last_byte;
	logic [SLOT_W-1:0] slot_number;
	logic [NODE_W-1:0] node_choice;

	modport source (
		output valid, mode, key_byte, last_byte, slot_number, node_choice,
		input  ready
	);

	modport sink (
		input  valid, mode, key_byte, last_byte, slot_number, node_choice,
		output ready
	);

endinterface

>>> rtl/core/ksr_out_if.sv
interface ksr_out_if;
	import ksr_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   key_slot;
	logic [NODE_W-1:0]   target_node;
	logic [STATUS_W-1:0] route_status;

	modport source (
		output valid, key_slot, target_node, route_status,
		input  ready
	);

	modport sink (
		input  valid, key_slot, target_node, route_status,
		output ready
	);

endinterface

>>> rtl/core/ksr_slot_map.sv
module ksr_slot_map #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ksr_pkg::entry_t       rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [ksr_pkg::NODE_W-1:0] wr_node,
	output logic                  busy
);
	import ksr_pkg::*;

	entry_t        mem [DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic          busy_q;

	// sweep every entry to unassigned after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= {1'b1, wr_node};
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

>>> rtl/core/key_slot_router.sv
// channel  dir  words                                   fields
// in       in   key byte or slot assignment             mode key_byte last_byte
//                                                       slot_number node_choice
// out      out  one route per key                       key_slot target_node route_status
// cfg      in   active node count, write only           cfg_wen cfg_wdata
//
// one input word per cycle while in.ready is high; a key's route is registered in s5.
// the slot is crc mod SLOT_COUNT via a reciprocal multiply and a back multiply,
// two registered stages, then one synchronous read of the slot map.
// after reset every slot map entry is swept clear with in.ready low.
// stages are elastic: a stalled output only holds back the words behind it.
module key_slot_router #(
	parameter int SLOT_COUNT = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ksr_in_if.sink                      in,
	ksr_out_if.source                   out,
	input  logic                        cfg_wen,
	input  logic [ksr_pkg::COUNT_W-1:0] cfg_wdata
);
	import ksr_pkg::*;

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int RECIP_W = 25;
	localparam int PROD_W = CRC_W + RECIP_W;
	localparam int Q_W = 8;
	localparam int QC_W = Q_W + 17;
	localparam logic [16:0] SC = 17'(SLOT_COUNT);
	// exact quotient for any 16-bit numerator with a 32-bit shift
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << 32) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [KEY_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

	logic [COUNT_W-1:0] active_nodes_q;
	logic [CRC_W-1:0]   crc_q;
	logic [CRC_W-1:0]   crc_next;
	logic               accept;
	logic               busy;

	logic              v_s1, asg_s1, v_s2, asg_s2, v_s3, asg_s3, v_s4, asg_s4, v_s5;
	logic [CRC_W-1:0]  crc_s1, crc_s2, crc_s3;
	logic [NODE_W-1:0] node_s1, node_s2, node_s3, node_s4;
	logic [Q_W-1:0]    q_s2;
	logic [CRC_W-1:0]  qc_s3;
	logic [AW-1:0]     addr_s4, slot_s5;
	entry_t            rdata_s5;
	logic              r1, r2, r3, r4, r5;
	logic [PROD_W-1:0] prod;
	logic [QC_W-1:0]   qc_full;
	logic [CRC_W-1:0]  rem;
	logic              lookup_in, assign_in;

	assign r5 = !v_s5 || out.ready;
	assign r4 = !v_s4 || r5;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;

	assign in.ready = r1 && !busy;
	assign accept   = in.valid && in.ready;
	assign crc_next = crc_feed(crc_q, in.key_byte);

	assign lookup_in = (in.mode == MODE_KEY) && in.last_byte;
	// assignments past the end of the map are dropped
	assign assign_in = (in.mode == MODE_ASSIGN) && (17'(in.slot_number) < SC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_nodes_q <= '0;
		end else if (cfg_wen) begin
			active_nodes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (accept && in.mode == MODE_KEY) begin
			crc_q <= in.last_byte ? '0 : crc_next;
		end
	end

	assign prod    = PROD_W'(crc_s1) * PROD_W'(RECIP);
	assign qc_full = QC_W'(q_s2) * QC_W'(SC);
	assign rem     = crc_s3 - qc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (r1) v_s1 <= accept && (lookup_in || assign_in);
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4 && !asg_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (r1) begin
			asg_s1  <= in.mode == MODE_ASSIGN;
			// an assignment carries its slot in the crc field
			crc_s1  <= (in.mode == MODE_ASSIGN) ? CRC_W'(in.slot_number) : crc_next;
			node_s1 <= in.node_choice;
		end
		if (r2) begin
			asg_s2  <= asg_s1;
			crc_s2  <= crc_s1;
			node_s2 <= node_s1;
			q_s2    <= prod[32 +: Q_W];
		end
		if (r3) begin
			asg_s3  <= asg_s2;
			crc_s3  <= crc_s2;
			node_s3 <= node_s2;
			qc_s3   <= qc_full[CRC_W-1:0];
		end
		if (r4) begin
			asg_s4  <= asg_s3;
			addr_s4 <= asg_s3 ? crc_s3[AW-1:0] : rem[AW-1:0];
			node_s4 <= node_s3;
		end
		if (r5) begin
			slot_s5 <= addr_s4;
		end
	end

	// reads and writes both happen as s4 drains, so map order follows word order
	ksr_slot_map #(
		.DEPTH(SLOT_COUNT),
		.AW   (AW)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (r5 && v_s4 && !asg_s4),
		.rd_addr(addr_s4),
		.rd_data(rdata_s5),
		.wr_en  (r5 && v_s4 && asg_s4),
		.wr_addr(addr_s4),
		.wr_node(node_s4),
		.busy   (busy)
	);

	assign out.valid       = v_s5;
	assign out.key_slot    = SLOT_W'(slot_s5);
	assign out.target_node = rdata_s5[ENTRY_W-1] ? rdata_s5[NODE_W-1:0] : '0;
	assign out.route_status = rdata_s5[ENTRY_W-1] ? ROUTE_MAPPED :
		(active_nodes_q != '0) ? ROUTE_DEFAULT : ROUTE_NONE;

endmodule

>>> sim/key_slot_router_tb.sv
`timescale 1ns / 1ps

module key_slot_router_tb;
	import ksr_pkg::*;

	localparam int SLOTS       = 16384;
	localparam int HOLD_LONG   = 1500;
	localparam int IDLE_LIMIT  = 50000;
	localparam int PHASE_WORDS = 180;
	localparam int POOL_KEYS   = 8;
	localparam int KEY_MAX     = 16;

	typedef struct packed {
		logic              mode;
		logic [KEY_W-1:0]  key_byte;
		logic              last_byte;
		logic [SLOT_W-1:0] slot_number;
		logic [NODE_W-1:0] node_choice;
	} word_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   key_slot;
		logic [NODE_W-1:0]   target_node;
		logic [STATUS_W-1:0] route_status;
	} route_t;

	// a word to send, with a route typed in by hand when typed is set
	typedef struct packed {
		word_t  w;
		logic   typed;
		route_t r;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [COUNT_W-1:0] cfg_wdata;

	ksr_in_if  in_ch ();
	ksr_out_if out_ch ();

	key_slot_router #(.SLOT_COUNT(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in_ch),
		.out       (out_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// predictor state
	logic [CRC_W-1:0]   key_crc = '0;
	entry_t             slot_table [SLOTS] = '{default: '0};
	logic [COUNT_W-1:0] cfg_nodes = '0;

	route_t route_q [$];
	row_t   pending_rows [$];
	row_t   dir_rows [$];

	logic [KEY_W-1:0] pool_kb [POOL_KEYS][KEY_MAX];
	int               pool_len [POOL_KEYS];
	int               pool_n = 0;

	int mismatches  = 0;
	int idle_cycles = 0;
	bit sink_hold   = 1'b0;
	bit src_rush    = 1'b0;
	int src_left    = 0;
	bit src_calm    = 1'b0;
	int snk_left    = 0;
	bit snk_calm    = 1'b0;

	function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] crc,
			input logic [KEY_W-1:0] b);
		logic [CRC_W-1:0] c;
		int i;
		c = crc ^ {b, 8'h00};
		for (i = 0; i < 8; i++)
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	task automatic route_word(input word_t w, output bit got, output route_t r);
		logic [CRC_W-1:0] s;
		entry_t e;
		got = 1'b0;
		r = '0;
		if (w.mode == MODE_ASSIGN) begin
			if (w.slot_number < SLOTS)
				slot_table[w.slot_number] = {1'b1, w.node_choice};
		end else begin
			key_crc = crc_next(key_crc, w.key_byte);
			if (w.last_byte) begin
				s = CRC_W'(key_crc % SLOTS);
				key_crc = '0;
				e = slot_table[s[SLOT_W-1:0]];
				got = 1'b1;
				r.key_slot = s[SLOT_W-1:0];
				if (e[ENTRY_W-1]) begin
					r.target_node = e[NODE_W-1:0];
					r.route_status = ROUTE_MAPPED;
				end else if (cfg_nodes != 0) begin
					r.target_node = '0;
					r.route_status = ROUTE_DEFAULT;
				end else begin
					r.target_node = '0;
					r.route_status = ROUTE_NONE;
				end
			end
		end
	endtask

	function automatic word_t key_word(input logic [KEY_W-1:0] b, input logic last);
		word_t w;
		w.mode = MODE_KEY;
		w.key_byte = b;
		w.last_byte = last;
		w.slot_number = SLOT_W'($urandom);
		w.node_choice = NODE_W'($urandom);
		return w;
	endfunction

	function automatic word_t assign_word(input logic [SLOT_W-1:0] slot,
			input logic [NODE_W-1:0] node);
		word_t w;
		w.mode = MODE_ASSIGN;
		w.key_byte = KEY_W'($urandom);
		w.last_byte = 1'($urandom);
		w.slot_number = slot;
		w.node_choice = node;
		return w;
	endfunction

	function automatic row_t plain(input word_t w);
		row_t row;
		row.w = w;
		row.typed = 1'b0;
		row.r = '0;
		return row;
	endfunction

	function automatic row_t mk_row(input word_t w, input logic typed,
			input logic [SLOT_W-1:0] slot, input logic [NODE_W-1:0] node,
			input logic [STATUS_W-1:0] status);
		row_t row;
		row.w = w;
		row.typed = typed;
		row.r = {slot, node, status};
		return row;
	endfunction

	// take each accepted word into the predictor
	always @(posedge clk) begin : take_word
		word_t  w;
		row_t   h;
		bit     got;
		route_t r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			w = {in_ch.mode, in_ch.key_byte, in_ch.last_byte, in_ch.slot_number,
				in_ch.node_choice};
			h = '0;
			if (pending_rows.size() != 0)
				h = pending_rows.pop_front();
			route_word(w, got, r);
			if (h.typed)
				route_q.push_back(h.r);
			else if (got)
				route_q.push_back(r);
		end
	end

	always @(posedge clk) begin : check_route
		route_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (route_q.size() == 0) begin
				$display("%0t: unexpected route, expected none, got slot %h node %h status %h",
					$time, out_ch.key_slot, out_ch.target_node, out_ch.route_status);
				mismatches++;
			end else begin
				e = route_q.pop_front();
				if (out_ch.key_slot !== e.key_slot) begin
					$display("%0t: key_slot expected %h got %h", $time, e.key_slot,
						out_ch.key_slot);
					mismatches++;
				end
				if (out_ch.target_node !== e.target_node) begin
					$display("%0t: target_node expected %h got %h", $time, e.target_node,
						out_ch.target_node);
					mismatches++;
				end
				if (out_ch.route_status !== e.route_status) begin
					$display("%0t: route_status expected %h got %h", $time, e.route_status,
						out_ch.route_status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// route receiver
	initial begin : sink
		int gap;
		bit held;
		held = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold && !held) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_LONG) @(posedge clk);
				held = 1'b1;
			end
			if (snk_left == 0) begin
				snk_left = $urandom_range(8, 40);
				snk_calm = ($urandom_range(0, 3) == 0);
			end
			snk_left--;
			gap = snk_calm ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
		end
	end

	task automatic offer(input row_t row);
		int gap;
		if (src_left == 0) begin
			src_left = $urandom_range(8, 40);
			src_calm = ($urandom_range(0, 3) == 0);
		end
		src_left--;
		gap = (src_calm || src_rush) ? 0 : $urandom_range(0, 11);
		pending_rows.push_back(row);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= row.w.mode;
		in_ch.key_byte    <= row.w.key_byte;
		in_ch.last_byte   <= row.w.last_byte;
		in_ch.slot_number <= row.w.slot_number;
		in_ch.node_choice <= row.w.node_choice;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_nodes(input logic [COUNT_W-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_nodes = v;
		cfg_wen <= 1'b0;
	endtask

	// let every route drain, then the pipeline behind any assign word
	task automatic settle();
		in_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (route_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_phase(input int n);
		logic [KEY_W-1:0] kb [KEY_MAX];
		logic [CRC_W-1:0] c;
		int len, sent, p, i;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 12) begin
				offer(plain(assign_word(SLOT_W'($urandom), NODE_W'($urandom))));
				sent++;
			end else begin
				if (pool_n > 0 && $urandom_range(0, 2) == 0) begin
					p = $urandom_range(0, pool_n - 1);
					len = pool_len[p];
					for (i = 0; i < len; i++)
						kb[i] = pool_kb[p][i];
				end else begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, KEY_MAX)
						: $urandom_range(1, 4);
					for (i = 0; i < len; i++) begin
						case ($urandom_range(0, 7))
							0: kb[i] = 8'h00;
							1: kb[i] = 8'hFF;
							default: kb[i] = KEY_W'($urandom);
						endcase
					end
					if (pool_n < POOL_KEYS) begin
						p = pool_n;
						pool_n++;
					end else begin
						p = $urandom_range(0, POOL_KEYS - 1);
					end
					pool_len[p] = len;
					for (i = 0; i < len; i++)
						pool_kb[p][i] = kb[i];
				end
				// map the key's own slot now and then so mapped routes show up
				if ($urandom_range(0, 2) == 0) begin
					c = '0;
					for (i = 0; i < len; i++)
						c = crc_next(c, kb[i]);
					offer(plain(assign_word(SLOT_W'(c % SLOTS), NODE_W'($urandom))));
					sent++;
				end
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 19) == 0) begin
						offer(plain(assign_word(SLOT_W'($urandom), NODE_W'($urandom))));
						sent++;
					end
					// a dropped last mark runs this key into the next one
					offer(plain(key_word(kb[i], i == len - 1 && $urandom_range(0, 29) != 0)));
					sent++;
				end
			end
		end
	endtask

	initial begin : stim
		int i;
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.mode        = MODE_KEY;
		in_ch.key_byte    = '0;
		in_ch.last_byte   = 1'b0;
		in_ch.slot_number = '0;
		in_ch.node_choice = '0;

		// zero key gives slot 0, a lone 0x01 byte gives the polynomial itself
		dir_rows.push_back(mk_row(key_word(8'h00, 1'b1), 1'b1, 14'h0000, 4'h0, ROUTE_NONE));
		dir_rows.push_back(mk_row(key_word(8'h01, 1'b1), 1'b1, 14'h1021, 4'h0, ROUTE_NONE));
		dir_rows.push_back(plain(assign_word(14'h1021, 4'hF)));
		dir_rows.push_back(mk_row(key_word(8'h01, 1'b1), 1'b1, 14'h1021, 4'hF, ROUTE_MAPPED));
		dir_rows.push_back(plain(key_word(8'h00, 1'b0)));
		dir_rows.push_back(mk_row(key_word(8'h00, 1'b1), 1'b1, 14'h0000, 4'h0, ROUTE_NONE));
		dir_rows.push_back(plain(assign_word(14'h0000, 4'h0)));
		dir_rows.push_back(mk_row(key_word(8'h00, 1'b1), 1'b1, 14'h0000, 4'h0, ROUTE_MAPPED));
		dir_rows.push_back(plain(assign_word(14'h3FFF, 4'hF)));
		dir_rows.push_back(plain(key_word(8'hFF, 1'b0)));
		dir_rows.push_back(plain(key_word(8'hFF, 1'b1)));
		dir_rows.push_back(plain({MODE_KEY, 8'h01, 1'b0, 14'h3FFF, 4'hF}));
		// assign in the middle of a key leaves the running crc alone
		dir_rows.push_back(plain(assign_word(14'h0005, 4'h3)));
		dir_rows.push_back(plain({MODE_KEY, 8'h00, 1'b1, 14'h0000, 4'h0}));
		dir_rows.push_back(plain(assign_word(14'h1021, 4'h5)));
		dir_rows.push_back(mk_row(key_word(8'h01, 1'b1), 1'b1, 14'h1021, 4'h5, ROUTE_MAPPED));
		dir_rows.push_back(plain(key_word(8'h80, 1'b1)));
		dir_rows.push_back(plain(key_word(8'h7F, 1'b1)));
		dir_rows.push_back(plain({MODE_ASSIGN, 8'hFF, 1'b1, 14'h2AAA, 4'hA}));
		dir_rows.push_back(plain(key_word(8'h55, 1'b1)));
		dir_rows.push_back(plain(key_word(8'hAA, 1'b1)));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slot map sweep runs now; in.ready stays low until it is done
		set_nodes(5'd0);
		for (i = 0; i < dir_rows.size(); i++)
			offer(dir_rows[i]);
		run_phase(PHASE_WORDS);
		settle();

		// receiver holds off while single-byte keys pour in
		set_nodes(5'd16);
		src_rush = 1'b1;
		sink_hold = 1'b1;
		for (i = 0; i < 80; i++)
			offer(plain(key_word(KEY_W'($urandom), 1'b1)));
		src_rush = 1'b0;
		run_phase(PHASE_WORDS - 80);
		settle();

		set_nodes(5'd1);
		run_phase(PHASE_WORDS);
		settle();

		set_nodes(5'd31);
		run_phase(PHASE_WORDS);
		settle();

		set_nodes(COUNT_W'($urandom_range(2, 30)));
		run_phase(PHASE_WORDS);
		settle();

		set_nodes(5'd0);
		run_phase(PHASE_WORDS);
		settle();

		if (mismatches == 0 && route_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0t: %0d mismatches, %0d routes outstanding", $time, mismatches,
				route_q.size());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
